[rtl/tcw_pkg.sv]
// Shared constants, types and helpers for the text console writer.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Field widths
    localparam int OPC_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int ENTRY_W = CHAR_W + COLOR_W;

    // Stream widths (whole bytes); the opcode travels in tuser
    localparam int S_FIELDS_W = CHAR_W + COLOR_W + ROW_W + COL_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ENTRY_W + ROW_W + COL_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;

    localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    localparam logic [ROW_W-1:0]  ROW_LIMIT = ROW_W'(ROWS);
    localparam logic [COL_W-1:0]  COL_LIMIT = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(CELLS - 1);

    typedef enum logic [OPC_W-1:0] {
        OP_PUT_CHAR   = 3'd0,
        OP_NEW_LINE   = 3'd1,
        OP_WRITE_CELL = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_READ_CELL  = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_DONE
    } state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;     // item taken this cycle
        logic cnt_clr;    // sweep counter to zero
        logic cnt_inc;    // sweep counter step
        logic copy;       // scroll copy: read cell cnt + one row
        logic fill;       // write fill entry at cnt
        logic fill_init;  // fill with the reset entry
        logic out_load;   // load result register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic need_scroll;
        logic is_clear;
        logic copy_last;
        logic fill_last;
        logic out_free;
    } status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(ADDR_W'(row) * ROW_STEP) + ADDR_W'(col);
    endfunction

endpackage

[rtl/tcw_ctrl.sv]
// Sequencer for the text console writer: item intake, scroll and fill sweeps.
module tcw_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tcw_pkg::status_t sts,
    output tcw_pkg::cmd_t    cmd
);

    tcw_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcw_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            tcw_pkg::ST_INIT: begin
                cmd.fill      = 1'b1;
                cmd.fill_init = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (sts.fill_last) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept  = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    if (sts.need_scroll) begin
                        state_next = tcw_pkg::ST_COPY;
                    end else if (sts.is_clear) begin
                        state_next = tcw_pkg::ST_FILL;
                    end else begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                end
            end
            tcw_pkg::ST_COPY: begin
                cmd.copy    = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.copy_last) begin
                    state_next = tcw_pkg::ST_DRAIN;
                end
            end
            tcw_pkg::ST_DRAIN: begin
                // last copied entry is written this cycle
                state_next = tcw_pkg::ST_FILL;
            end
            tcw_pkg::ST_FILL: begin
                cmd.fill    = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (sts.fill_last) begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcw_pkg::ST_INIT;
            end
        endcase
    end

endmodule

[rtl/tcw_datapath.sv]
// Cell store, cursor, color register, sweep counter and result register.
module tcw_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tcw_pkg::cmd_t                      cmd,
    output tcw_pkg::status_t                   sts,
    input  logic [tcw_pkg::OPC_W-1:0]          opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]        cell_color,
    input  logic [tcw_pkg::ROW_W-1:0]          cell_row,
    input  logic [tcw_pkg::COL_W-1:0]          cell_col,
    input  logic                               cfg_valid,
    input  logic [tcw_pkg::COLOR_W-1:0]        cfg_data,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [tcw_pkg::M_DATA_W-1:0]       m_tdata
);

    logic [tcw_pkg::ENTRY_W-1:0] mem [tcw_pkg::CELLS];

    logic [tcw_pkg::ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic [tcw_pkg::COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [tcw_pkg::COLOR_W-1:0] color_reg;
    logic [tcw_pkg::ADDR_W-1:0]  cnt_reg, cnt_next;
    logic                        pend_reg;
    logic [tcw_pkg::ADDR_W-1:0]  pend_addr_reg;
    logic [tcw_pkg::ENTRY_W-1:0] rdata_reg;
    logic                        scrolled_reg, scrolled_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic                        m_valid_reg, m_valid_next;
    logic [tcw_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                        is_put, is_nl, is_wr, is_clr, is_rd;
    logic                        in_range, last_row, last_col;
    logic [tcw_pkg::ADDR_W-1:0]  item_addr, cur_addr;
    logic                        we, re;
    logic [tcw_pkg::ADDR_W-1:0]  waddr, raddr;
    logic [tcw_pkg::ENTRY_W-1:0] wdata, out_entry;

    assign is_put = (opcode == tcw_pkg::OP_PUT_CHAR);
    assign is_nl  = (opcode == tcw_pkg::OP_NEW_LINE);
    assign is_wr  = (opcode == tcw_pkg::OP_WRITE_CELL);
    assign is_clr = (opcode == tcw_pkg::OP_CLEAR);
    assign is_rd  = (opcode == tcw_pkg::OP_READ_CELL);

    assign in_range  = (cell_row < tcw_pkg::ROW_LIMIT) && (cell_col < tcw_pkg::COL_LIMIT);
    assign last_row  = (cur_row_reg == tcw_pkg::LAST_ROW);
    assign last_col  = (cur_col_reg == tcw_pkg::LAST_COL);
    assign item_addr = tcw_pkg::cell_addr(cell_row, cell_col);
    assign cur_addr  = tcw_pkg::cell_addr(cur_row_reg, cur_col_reg);

    assign sts.need_scroll = (is_put && last_col && last_row) || (is_nl && last_row);
    assign sts.is_clear    = is_clr;
    assign sts.copy_last   = (cnt_reg == tcw_pkg::COPY_LAST);
    assign sts.fill_last   = (cnt_reg == tcw_pkg::FILL_LAST);
    assign sts.out_free    = !m_valid_reg || m_tready;

    // Cursor update at intake
    always_comb begin
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        scrolled_next = scrolled_reg;
        rd_ok_next    = rd_ok_reg;
        if (cmd.accept) begin
            scrolled_next = sts.need_scroll;
            rd_ok_next    = is_rd && in_range;
            unique case (opcode)
                tcw_pkg::OP_PUT_CHAR: begin
                    if (last_col) begin
                        cur_col_next = '0;
                        if (!last_row) begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end else begin
                        cur_col_next = cur_col_reg + 1'b1;
                    end
                end
                tcw_pkg::OP_NEW_LINE: begin
                    cur_col_next = '0;
                    if (!last_row) begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                tcw_pkg::OP_CLEAR: begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Store write port: pending scroll copy first, then item, then fill
    always_comb begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = {color_reg, tcw_pkg::SPACE_CHAR};
        priority if (pend_reg) begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = rdata_reg;
        end else if (cmd.accept && is_put) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {color_reg, char_code};
        end else if (cmd.accept && is_wr && in_range) begin
            we    = 1'b1;
            waddr = item_addr;
            wdata = {cell_color, char_code};
        end else if (cmd.fill) begin
            we    = 1'b1;
            waddr = cnt_reg;
            wdata = cmd.fill_init ? {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CHAR}
                                  : {color_reg, tcw_pkg::SPACE_CHAR};
        end else begin
            we = 1'b0;
        end
    end

    assign re    = cmd.copy || (cmd.accept && is_rd && in_range);
    assign raddr = cmd.copy ? (cnt_reg + tcw_pkg::ROW_STEP) : item_addr;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign cnt_next = cmd.cnt_clr ? '0 : (cmd.cnt_inc ? cnt_reg + 1'b1 : cnt_reg);

    // Result register
    assign out_entry    = rd_ok_reg ? rdata_reg : '0;
    assign m_valid_next = cmd.out_load || (m_valid_reg && !m_tready);
    assign m_data_next  = cmd.out_load
                        ? {{tcw_pkg::M_PAD_W{1'b0}}, scrolled_reg, cur_col_reg,
                           cur_row_reg, out_entry}
                        : m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            color_reg    <= tcw_pkg::RESET_COLOR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            scrolled_reg <= 1'b0;
            rd_ok_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            if (cfg_valid) begin
                color_reg <= cfg_data;
            end
            cnt_reg      <= cnt_next;
            pend_reg     <= cmd.copy;
            scrolled_reg <= scrolled_next;
            rd_ok_reg    <= rd_ok_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= cnt_reg;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/text_console_writer.sv]
// Top level of the text console writer: 80x25 text-cell store with cursor.
//
// Keeps an 80x25 store of 16-bit cells (character in the low byte, color in
// the high byte) and a cursor. Each input item carries one opcode in s_tuser:
// put_char (raw byte at the cursor, then advance), new_line, write_cell,
// clear and read_cell; every item returns exactly one result item with the
// read entry (zero unless read_cell hits a valid cell), the cursor after the
// operation and a scrolled flag. After reset the block sweeps the whole
// store to spaces in color 7, one cell per cycle, with s_tready low (color
// writes are taken meanwhile). One item at a time is in work; an ordinary
// item passes through the DONE state, where its result is loaded into the
// output register once that register is free, and s_tready returns together
// with the result. A scroll (put_char wrapping off the last row, new_line
// on the last row) runs a row-copy sweep through the single read and single
// write port of the store, one cell per cycle, then a drain state and a fill
// of the 80 cells of the last row. clear refills all 2000 cells. A new item
// is accepted while the previous result still waits on m_tready; its result
// is then held until the output register frees.
// The text color register may be written at any time the block is idle;
// cfg_ready is always high.
module text_console_writer (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input items
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [2:0] opcode
    input  logic [tcw_pkg::OPC_W-1:0]    s_tuser,
    // [7:0] char_code, [15:8] cell_color, [20:16] cell_row,
    // [27:21] cell_col, [31:28] zero
    input  logic [tcw_pkg::S_DATA_W-1:0] s_tdata,
    // Result items
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] cell_entry, [20:16] cursor_row, [27:21] cursor_col,
    // [28] scrolled, [31:29] zero
    output logic [tcw_pkg::M_DATA_W-1:0] m_tdata,
    // Text color register write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data
);

    localparam int CHAR_LSB  = 0;
    localparam int COLOR_LSB = CHAR_LSB + tcw_pkg::CHAR_W;
    localparam int ROW_LSB   = COLOR_LSB + tcw_pkg::COLOR_W;
    localparam int COL_LSB   = ROW_LSB + tcw_pkg::ROW_W;

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t sts;

    logic [tcw_pkg::OPC_W-1:0]   in_opcode;
    logic [tcw_pkg::CHAR_W-1:0]  in_char;
    logic [tcw_pkg::COLOR_W-1:0] in_color;
    logic [tcw_pkg::ROW_W-1:0]   in_row;
    logic [tcw_pkg::COL_W-1:0]   in_col;

    // Unpack the input item
    assign in_opcode = s_tuser;
    assign in_char   = s_tdata[CHAR_LSB  +: tcw_pkg::CHAR_W];
    assign in_color  = s_tdata[COLOR_LSB +: tcw_pkg::COLOR_W];
    assign in_row    = s_tdata[ROW_LSB   +: tcw_pkg::ROW_W];
    assign in_col    = s_tdata[COL_LSB   +: tcw_pkg::COL_W];

    // Color register can always be written
    assign cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (in_opcode),
        .char_code  (in_char),
        .cell_color (in_color),
        .cell_row   (in_row),
        .cell_col   (in_col),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

[sim/text_console_writer_checker.sv]
// Checker for the text console writer: predicts each result item and compares it.
`timescale 1ns / 1ps
module text_console_writer_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [tcw_pkg::OPC_W-1:0]    s_tuser,
    input  logic [tcw_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [tcw_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]  cfg_data,
    output int                           failures,
    output int                           pending,
    output int                           scroll_count
);

    // Input item fields, char code in the low bits
    typedef struct packed {
        logic [tcw_pkg::COL_W-1:0]   col;
        logic [tcw_pkg::ROW_W-1:0]   row;
        logic [tcw_pkg::COLOR_W-1:0] color;
        logic [tcw_pkg::CHAR_W-1:0]  ch;
    } console_cmd_t;

    // Result item, entry in the low bits
    typedef struct packed {
        logic                        scrolled;
        logic [tcw_pkg::COL_W-1:0]   col;
        logic [tcw_pkg::ROW_W-1:0]   row;
        logic [tcw_pkg::ENTRY_W-1:0] entry;
    } console_result_t;

    logic [tcw_pkg::ENTRY_W-1:0] screen [tcw_pkg::CELLS];
    logic [tcw_pkg::ROW_W-1:0]   cur_row;
    logic [tcw_pkg::COL_W-1:0]   cur_col;
    logic [tcw_pkg::COLOR_W-1:0] text_color;
    console_result_t             expected_q [$];

    function automatic int cell_index(logic [tcw_pkg::ROW_W-1:0] r,
                                      logic [tcw_pkg::COL_W-1:0] c);
        return int'(r) * tcw_pkg::COLUMNS + int'(c);
    endfunction

    // Spaces in the current color from cell 'first' to the end
    function automatic void blank_from(int first);
        int i;
        for (i = first; i < tcw_pkg::CELLS; i++) screen[i] = {text_color, tcw_pkg::SPACE_CHAR};
    endfunction

    function automatic void scroll_screen();
        int i;
        for (i = 0; i < tcw_pkg::CELLS - tcw_pkg::COLUMNS; i++)
            screen[i] = screen[i + tcw_pkg::COLUMNS];
        blank_from(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
        scroll_count++;
    endfunction

    // Cursor down one row; scrolls instead on the last row
    function automatic logic line_down();
        if (cur_row == tcw_pkg::LAST_ROW) begin
            scroll_screen();
            return 1'b1;
        end
        cur_row++;
        return 1'b0;
    endfunction

    function automatic console_result_t console_step(logic [tcw_pkg::OPC_W-1:0] opc,
                                                     console_cmd_t cmd);
        console_result_t res;
        logic            in_range;
        res      = '0;
        in_range = (cmd.row < tcw_pkg::ROW_LIMIT) && (cmd.col < tcw_pkg::COL_LIMIT);
        case (opc)
            tcw_pkg::OP_PUT_CHAR: begin
                screen[cell_index(cur_row, cur_col)] = {text_color, cmd.ch};
                if (cur_col == tcw_pkg::LAST_COL) begin
                    cur_col      = '0;
                    res.scrolled = line_down();
                end else begin
                    cur_col++;
                end
            end
            tcw_pkg::OP_NEW_LINE: begin
                cur_col      = '0;
                res.scrolled = line_down();
            end
            tcw_pkg::OP_WRITE_CELL: begin
                if (in_range) screen[cell_index(cmd.row, cmd.col)] = {cmd.color, cmd.ch};
            end
            tcw_pkg::OP_CLEAR: begin
                blank_from(0);
                cur_row = '0;
                cur_col = '0;
            end
            tcw_pkg::OP_READ_CELL: begin
                if (in_range) res.entry = screen[cell_index(cmd.row, cmd.col)];
            end
            default: ;
        endcase
        res.row = cur_row;
        res.col = cur_col;
        return res;
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        if (!aresetn) begin
            text_color = tcw_pkg::RESET_COLOR;
            blank_from(0);
            cur_row = '0;
            cur_col = '0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) text_color = cfg_data;
            // results first: an item taken at this edge cannot have its result here
            if (m_tvalid && m_tready) begin
                got = console_result_t'(m_tdata[tcw_pkg::M_FIELDS_W-1:0]);
                if (expected_q.size() == 0) begin
                    failures++;
                    $display("%0t: result item 0x%0h arrived with nothing expected",
                             $time, got);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("cell_entry", 32'(want.entry), 32'(got.entry));
                    compare_field("cursor_row", 32'(want.row), 32'(got.row));
                    compare_field("cursor_col", 32'(want.col), 32'(got.col));
                    compare_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(console_step(s_tuser,
                    console_cmd_t'(s_tdata[tcw_pkg::S_FIELDS_W-1:0])));
        end
        pending = expected_q.size();
    end

endmodule

[sim/text_console_writer_tb.sv]
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module text_console_writer_tb;

    localparam int OPC_W    = tcw_pkg::OPC_W;
    localparam int CHAR_W   = tcw_pkg::CHAR_W;
    localparam int COLOR_W  = tcw_pkg::COLOR_W;
    localparam int ROW_W    = tcw_pkg::ROW_W;
    localparam int COL_W    = tcw_pkg::COL_W;
    localparam int S_DATA_W = tcw_pkg::S_DATA_W;
    localparam int M_DATA_W = tcw_pkg::M_DATA_W;

    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 185;   // random items per color setting
    localparam int NO_GAP_PHASE   = 3;     // phase run without any idle cycles
    localparam int HOLD_AT_RESULT = 330;   // result index where the sink holds off
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;     // idle margin before a color write
    localparam int DRAIN_CYCLES   = 20;
    // reset sweep and each scroll or clear sweep the store with no item handshake
    localparam int QUIET_LIMIT    = 12000;
    localparam logic [OPC_W-1:0] OP_FIRST_UNUSED = OPC_W'(tcw_pkg::OP_READ_CELL + 1);
    localparam logic [OPC_W-1:0] OP_LAST_UNUSED  = '1;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [OPC_W-1:0]    s_tuser   = '0;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COLOR_W-1:0]  cfg_data  = '0;

    int failures;
    int pending;
    int scroll_count;
    bit no_gaps = 1'b0;        // both sides skip idle cycles while set
    int items_sent = 0;
    int color_writes = 0;
    int op_count [1 << OPC_W];

    always begin
        #CLK_LOW  aclk = 1'b1;
        #CLK_HIGH aclk = 1'b0;
    end

    text_console_writer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    text_console_writer_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending),
        .scroll_count (scroll_count)
    );

    // Offer one item after a random gap and wait for its handshake.
    // Entered and left at a falling edge; valid stays high when the next gap is zero.
    task automatic send_item(input logic [OPC_W-1:0] opc, input logic [CHAR_W-1:0] ch,
                             input logic [COLOR_W-1:0] color,
                             input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= opc;
        s_tdata  <= S_DATA_W'({col, row, color, ch});
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        op_count[opc]++;
        items_sent++;
    endtask

    // Opcode with every other field random (ignored fields get noise too)
    task automatic send_op(input logic [OPC_W-1:0] opc);
        send_item(opc, CHAR_W'($urandom), COLOR_W'($urandom), ROW_W'($urandom),
                  COL_W'($urandom));
    endtask

    // Color write: only once the block has drained every result
    task automatic set_color(input logic [COLOR_W-1:0] color);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_data  <= color;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        color_writes++;
    endtask

    // Cell address for write/read: half the time anywhere on screen, often the bottom
    // rows where text lands, now and then fully random (out of range too)
    function automatic void pick_cell(output logic [ROW_W-1:0] r, output logic [COL_W-1:0] c);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            r = ROW_W'($urandom);
            c = COL_W'($urandom);
        end else if (sel < 5) begin
            r = ROW_W'($urandom_range(tcw_pkg::ROWS - 2, tcw_pkg::ROWS - 1));
            c = COL_W'($urandom_range(0, 15));
        end else begin
            r = ROW_W'($urandom_range(0, tcw_pkg::ROWS - 1));
            c = COL_W'($urandom_range(0, tcw_pkg::COLUMNS - 1));
        end
    endfunction

    // One short sequence of related items
    task automatic run_burst();
        int               kind;
        int               len;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // text run, often closed by a line break
            len = $urandom_range(1, 12);
            repeat (len) send_op(tcw_pkg::OP_PUT_CHAR);
            if ($urandom_range(0, 1)) send_op(tcw_pkg::OP_NEW_LINE);
        end else if (kind < 48) begin
            // a full line of text: the cursor wraps at least once
            repeat (tcw_pkg::COLUMNS) send_op(tcw_pkg::OP_PUT_CHAR);
        end else if (kind < 63) begin
            // store a cell and read it back
            pick_cell(r, c);
            send_item(tcw_pkg::OP_WRITE_CELL, CHAR_W'($urandom), COLOR_W'($urandom), r, c);
            send_item(tcw_pkg::OP_READ_CELL, CHAR_W'($urandom), COLOR_W'($urandom), r, c);
        end else if (kind < 78) begin
            pick_cell(r, c);
            send_item(tcw_pkg::OP_READ_CELL, CHAR_W'($urandom), COLOR_W'($urandom), r, c);
        end else if (kind < 88) begin
            // line breaks; on the bottom row each one scrolls
            len = $urandom_range(1, 3);
            repeat (len) send_op(tcw_pkg::OP_NEW_LINE);
        end else if (kind < 90) begin
            send_op(tcw_pkg::OP_CLEAR);
        end else begin
            // noise: any opcode, unused ones included, any field values
            send_op(OPC_W'($urandom_range(0, OP_LAST_UNUSED)));
        end
    endtask

    // Result sink: random stalls per item, one long hold-off mid-run so the
    // block backs up and drops s_tready while the sender keeps offering.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 9);
            if (taken == HOLD_AT_RESULT) gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
            taken++;
        end
    end

    // Watchdog: any handshake on any channel restarts the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no traffic for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, pending);
        $display("text_console_writer_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        logic [COLOR_W-1:0] phase_color [RANDOM_PHASES];
        int                 phase;
        int                 phase_end;
        int                 unused_ops;
        phase_color[0] = 8'h00;
        phase_color[1] = 8'h1E;
        phase_color[2] = COLOR_W'($urandom);
        phase_color[3] = 8'hA5;
        phase_color[4] = tcw_pkg::RESET_COLOR;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The color write goes in while the block still sweeps the store;
        // the store itself must still come up in the reset color.
        set_color(8'hFF);

        // Directed: reset contents, raw control bytes, field extremes,
        // out-of-range cells, unused opcodes, a line break and a clear.
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, '0, '0);
        send_item(tcw_pkg::OP_READ_CELL, '1, '1, tcw_pkg::LAST_ROW, tcw_pkg::LAST_COL);
        send_item(tcw_pkg::OP_PUT_CHAR, 8'h00, '0, '0, '0);
        send_item(tcw_pkg::OP_PUT_CHAR, 8'hFF, '1, '1, '1);
        send_item(tcw_pkg::OP_PUT_CHAR, 8'h0A, '0, '0, '0);     // line feed stays a plain byte
        send_item(tcw_pkg::OP_PUT_CHAR, 8'h0D, '0, '0, '0);     // so does carriage return
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, '0, COL_W'(1));
        send_item(tcw_pkg::OP_WRITE_CELL, 8'hFF, 8'h00, '0, '0);
        send_item(tcw_pkg::OP_WRITE_CELL, 8'h00, 8'hFF, tcw_pkg::LAST_ROW, tcw_pkg::LAST_COL);
        // row past the end, then column past the end
        send_item(tcw_pkg::OP_WRITE_CELL, 8'h55, 8'hAA, tcw_pkg::ROW_LIMIT, '0);
        send_item(tcw_pkg::OP_WRITE_CELL, 8'h55, 8'hAA, '0, tcw_pkg::COL_LIMIT);
        send_item(tcw_pkg::OP_WRITE_CELL, 8'h55, 8'hAA, '1, '1);
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, '0, '0);
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, tcw_pkg::LAST_ROW, tcw_pkg::LAST_COL);
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, tcw_pkg::ROW_LIMIT, '0);
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, '1, '1);
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, '0, tcw_pkg::COL_LIMIT);
        send_item(OP_FIRST_UNUSED, '1, '1, '1, '1);
        send_item(OP_LAST_UNUSED, '1, '1, '1, '1);
        send_item(tcw_pkg::OP_NEW_LINE, '0, '0, '0, '0);
        send_item(tcw_pkg::OP_CLEAR, '0, '0, '0, '0);             // blanks in color 0xFF
        send_item(tcw_pkg::OP_READ_CELL, '0, '0, tcw_pkg::LAST_ROW, tcw_pkg::LAST_COL);
        send_item(tcw_pkg::OP_PUT_CHAR, tcw_pkg::SPACE_CHAR, '0, '0, '0);

        // Random phases, each under its own text color
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_color(phase_color[phase]);
            no_gaps   = (phase == NO_GAP_PHASE);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_burst();
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        unused_ops = items_sent - op_count[tcw_pkg::OP_PUT_CHAR]
                     - op_count[tcw_pkg::OP_NEW_LINE] - op_count[tcw_pkg::OP_WRITE_CELL]
                     - op_count[tcw_pkg::OP_CLEAR] - op_count[tcw_pkg::OP_READ_CELL];
        $display("Ran %0d items: %0d put_char, %0d new_line, %0d write_cell, %0d clear,",
                 items_sent, op_count[tcw_pkg::OP_PUT_CHAR], op_count[tcw_pkg::OP_NEW_LINE],
                 op_count[tcw_pkg::OP_WRITE_CELL], op_count[tcw_pkg::OP_CLEAR]);
        $display("  %0d read_cell, %0d unused opcodes; %0d scrolls, %0d color writes",
                 op_count[tcw_pkg::OP_READ_CELL], unused_ops, scroll_count, color_writes);
        if (failures == 0)
            $display("text_console_writer_tb OK");
        else
            $display("text_console_writer_tb NOT OK");
        $finish;
    end

endmodule
